// File: sv/pat_pkg.sv
package pat_pkg;

  // Fixed field widths of the item and result channels.
  localparam int SLOT_W = 6;
  localparam int SEQ_W  = 32;
  localparam int PID_W  = 16;
  localparam int EXP_W  = 5;

  // Default sizing of the tally.
  localparam int DEF_SLOTS = 64;
  localparam int DEF_PEERS = 16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_UPD,
    ST_DONE
  } pat_state_t;

endpackage

// File: sv/pat_ram.sv
module pat_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read: data appears the cycle after the address.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/pat_ctrl.sv
module pat_ctrl #(
  parameter int SLOTS = pat_pkg::DEF_SLOTS,
  parameter int PEERS = pat_pkg::DEF_PEERS,
  parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  parameter int PW    = (PEERS > 1) ? $clog2(PEERS) : 1,
  parameter int CW    = $clog2(PEERS + 1),
  parameter int RW    = pat_pkg::SEQ_W + pat_pkg::PID_W + CW
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [pat_pkg::EXP_W-1:0]  expected,
  // item channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pat_pkg::SLOT_W-1:0] in_slot,
  input  logic [pat_pkg::SEQ_W-1:0]  in_proposed_seq,
  input  logic [pat_pkg::PID_W-1:0]  in_proposer,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_final_valid,
  output logic                       out_duplicate,
  output logic [pat_pkg::SLOT_W-1:0] out_final_slot,
  output logic [pat_pkg::SEQ_W-1:0]  out_final_seq,
  output logic [pat_pkg::PID_W-1:0]  out_final_proposer,
  // slot row memory
  output logic                       slot_we,
  output logic [SW-1:0]              slot_waddr,
  output logic [RW-1:0]              slot_wdata,
  output logic                       slot_re,
  output logic [SW-1:0]              slot_raddr,
  input  logic [RW-1:0]              slot_rdata,
  // seen proposer memory
  output logic                       seen_we,
  output logic [SW+PW-1:0]           seen_waddr,
  output logic [pat_pkg::PID_W-1:0]  seen_wdata,
  output logic                       seen_re,
  output logic [SW+PW-1:0]           seen_raddr,
  input  logic [pat_pkg::PID_W-1:0]  seen_rdata
);

  import pat_pkg::*;

  pat_state_t state_r, state_nxt;

  logic [SW-1:0]     clr_cnt_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [PID_W-1:0]  who_r;
  logic              in_range_r;
  logic [PW-1:0]     idx_r;
  logic [SEQ_W-1:0]  cur_seq_r;
  logic [PID_W-1:0]  cur_pid_r;
  logic [CW-1:0]     cur_cnt_r;
  logic              res_final_r;
  logic              res_dup_r;
  logic [SEQ_W-1:0]  res_seq_r;
  logic [PID_W-1:0]  res_pid_r;
  logic              out_valid_r;
  logic              out_final_r;
  logic              out_dup_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic [PID_W-1:0]  out_pid_r;

  logic              accept;
  logic              out_free;
  logic [SW-1:0]     slot_idx;
  logic [CW-1:0]     need;
  logic [SEQ_W-1:0]  row_seq;
  logic [PID_W-1:0]  row_pid;
  logic [CW-1:0]     row_cnt;
  logic              closed;
  logic              hit;
  logic              last;
  logic              better;
  logic [CW-1:0]     cnt_inc;
  logic [SEQ_W-1:0]  new_seq;
  logic [PID_W-1:0]  new_pid;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign slot_idx = SW'(slot_r);

  // Effective expected count, clamped to 1..PEERS.
  always_comb begin
    if (expected == '0) begin
      need = CW'(1);
    end else if (32'(expected) > 32'(PEERS)) begin
      need = CW'(PEERS);
    end else begin
      need = CW'(expected);
    end
  end

  assign {row_seq, row_pid, row_cnt} = slot_rdata;
  assign closed  = !in_range_r || (row_cnt >= need);
  assign hit     = (seen_rdata == who_r);
  assign last    = ((32'(idx_r) + 32'd1) == 32'(cur_cnt_r));
  assign better  = (cur_cnt_r == '0) || (seq_r > cur_seq_r) ||
                   ((seq_r == cur_seq_r) && (who_r < cur_pid_r));
  assign new_seq = better ? seq_r : cur_seq_r;
  assign new_pid = better ? who_r : cur_pid_r;
  assign cnt_inc = CW'(cur_cnt_r + 1'b1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == SW'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (closed) begin
          state_nxt = ST_DONE;
        end else if (row_cnt == '0) begin
          state_nxt = ST_UPD;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = ST_DONE;
        end else if (last) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory controls and handshake.
  always_comb begin
    in_stall   = 1'b1;
    slot_we    = 1'b0;
    slot_waddr = slot_idx;
    slot_wdata = {new_seq, new_pid, cnt_inc};
    slot_re    = 1'b0;
    slot_raddr = SW'(in_slot);
    seen_we    = 1'b0;
    seen_waddr = {slot_idx, PW'(cur_cnt_r)};
    seen_wdata = who_r;
    seen_re    = 1'b0;
    seen_raddr = {slot_idx, PW'(0)};
    unique case (state_r)
      ST_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_cnt_r;
        slot_wdata = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        slot_re  = accept;
      end
      ST_CHK: begin
        seen_re = !closed && (row_cnt != '0);
      end
      ST_SCAN: begin
        seen_re    = !hit && !last;
        seen_raddr = {slot_idx, PW'(idx_r + 1'b1)};
      end
      ST_UPD: begin
        slot_we = 1'b1;
        seen_we = 1'b1;
      end
      ST_DONE: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item datapath.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          slot_r     <= in_slot;
          seq_r      <= in_proposed_seq;
          who_r      <= in_proposer;
          in_range_r <= (32'(in_slot) < 32'(SLOTS));
        end
      end
      ST_CHK: begin
        cur_seq_r   <= row_seq;
        cur_pid_r   <= row_pid;
        cur_cnt_r   <= row_cnt;
        idx_r       <= '0;
        res_final_r <= 1'b0;
        res_dup_r   <= 1'b0;
        res_seq_r   <= '0;
        res_pid_r   <= '0;
      end
      ST_SCAN: begin
        idx_r     <= idx_r + 1'b1;
        res_dup_r <= hit;
      end
      ST_UPD: begin
        if (cnt_inc >= need) begin
          res_final_r <= 1'b1;
          res_seq_r   <= new_seq;
          res_pid_r   <= new_pid;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_final_r <= res_final_r;
          out_dup_r   <= res_dup_r;
          out_slot_r  <= slot_r;
          out_seq_r   <= res_seq_r;
          out_pid_r   <= res_pid_r;
        end
      end
      default: begin
        idx_r <= idx_r;
      end
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_final_valid    = out_final_r;
  assign out_duplicate      = out_dup_r;
  assign out_final_slot     = out_slot_r;
  assign out_final_seq      = out_seq_r;
  assign out_final_proposer = out_pid_r;

endmodule

// File: sv/proposal_agreement_tally_top.sv
// Proposal agreement tally. Each item is one proposal acknowledgement (slot,
// proposed sequence, proposer id) and produces exactly one result item. Per
// slot the block keeps the best proposal, the ack count and the ids already
// counted; a repeated proposer is flagged as a duplicate and changes nothing,
// and once the count reaches the expected number the result carries the
// agreed sequence and proposer. After reset the block clears every row of
// the slot memory and stalls the item channel meanwhile; the configuration
// port is taken at any time. The ids already stored for an item's slot (at
// most PEERS - 1) are compared one per cycle through the single read port
// of the seen proposer memory, up to the first match. Closed or out-of-range
// slots skip the comparison and the update. The next item is accepted in the
// cycle after its predecessor's result is registered, even while that result
// still waits on a stalled output.
module proposal_agreement_tally_top #(
  parameter int SLOTS = pat_pkg::DEF_SLOTS,
  parameter int PEERS = pat_pkg::DEF_PEERS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration: expected acknowledgement count.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pat_pkg::EXP_W-1:0]  cfg_expected_acks,
  // Acknowledgement items.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [pat_pkg::SLOT_W-1:0] in_slot,
  input  logic [pat_pkg::SEQ_W-1:0]  in_proposed_seq,
  input  logic [pat_pkg::PID_W-1:0]  in_proposer,
  // Result items.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_final_valid,
  output logic                       out_duplicate,
  output logic [pat_pkg::SLOT_W-1:0] out_final_slot,
  output logic [pat_pkg::SEQ_W-1:0]  out_final_seq,
  output logic [pat_pkg::PID_W-1:0]  out_final_proposer
);

  import pat_pkg::*;

  // Slot index, peer index and ack count widths.
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int CW = $clog2(PEERS + 1);
  // A slot row holds best sequence, best proposer and ack count.
  localparam int RW = SEQ_W + PID_W + CW;

  logic [EXP_W-1:0] expected_r;

  logic             slot_we;
  logic [SW-1:0]    slot_waddr;
  logic [RW-1:0]    slot_wdata;
  logic             slot_re;
  logic [SW-1:0]    slot_raddr;
  logic [RW-1:0]    slot_rdata;
  logic             seen_we;
  logic [SW+PW-1:0] seen_waddr;
  logic [PID_W-1:0] seen_wdata;
  logic             seen_re;
  logic [SW+PW-1:0] seen_raddr;
  logic [PID_W-1:0] seen_rdata;

  // The register is always writable; it is to be written only while no item
  // is in flight, since a change takes effect at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= EXP_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      expected_r <= cfg_expected_acks;
    end
  end

  // Per-slot best proposal and ack count, cleared by the pass after reset.
  pat_ram #(
    .AW (SW),
    .DW (RW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Proposer ids already counted, addressed by slot and arrival order.
  // Only entries below the slot's ack count are ever read, so no clearing.
  pat_ram #(
    .AW (SW + PW),
    .DW (PID_W)
  ) u_seen_ram (
    .clk   (clk),
    .we    (seen_we),
    .waddr (seen_waddr),
    .wdata (seen_wdata),
    .re    (seen_re),
    .raddr (seen_raddr),
    .rdata (seen_rdata)
  );

  pat_ctrl #(
    .SLOTS (SLOTS),
    .PEERS (PEERS),
    .SW    (SW),
    .PW    (PW),
    .CW    (CW),
    .RW    (RW)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .expected           (expected_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_slot            (in_slot),
    .in_proposed_seq    (in_proposed_seq),
    .in_proposer        (in_proposer),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_final_valid    (out_final_valid),
    .out_duplicate      (out_duplicate),
    .out_final_slot     (out_final_slot),
    .out_final_seq      (out_final_seq),
    .out_final_proposer (out_final_proposer),
    .slot_we            (slot_we),
    .slot_waddr         (slot_waddr),
    .slot_wdata         (slot_wdata),
    .slot_re            (slot_re),
    .slot_raddr         (slot_raddr),
    .slot_rdata         (slot_rdata),
    .seen_we            (seen_we),
    .seen_waddr         (seen_waddr),
    .seen_wdata         (seen_wdata),
    .seen_re            (seen_re),
    .seen_raddr         (seen_raddr),
    .seen_rdata         (seen_rdata)
  );

endmodule
